// ===== sv/trilinear_gather_scatter_store_core_macros.svh =====
// Assertion macros used by the controller RTL.
`ifndef TRILINEAR_GATHER_SCATTER_STORE_CORE_MACROS_SVH
`define TRILINEAR_GATHER_SCATTER_STORE_CORE_MACROS_SVH

// Checked at every edge, reset included.
`define TGSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is low.
`define TGSS_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== sv/tgss_pkg.sv =====
`default_nettype none

package tgss_pkg;

  localparam int POS_W   = 18;
  localparam int MUL_W   = 25;
  localparam int PROD_W  = 50;
  localparam int CHUNK_W = 24;
  localparam int OUT_W   = 32;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_READ    = 2'd1,
    OP_GATHER  = 2'd2,
    OP_SCATTER = 2'd3
  } op_t;

  typedef struct packed {
    op_t                command;
    logic [5:0]         entry_address;
    logic signed [31:0] value;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
    logic               shift_x;
    logic               shift_y;
    logic               shift_z;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               status;
  } rsp_beat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_RD_ISSUE,
    ST_RD_TAKE,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_M1,
    ST_M2,
    ST_TERM,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic decode;
    logic ld_write;
    logic rd_issue;
    logic rd_take;
    logic w1;
    logic w2;
    logic w3;
    logic m1;
    logic m2;
    logic term;
    logic acc;
    logic finish;
  } ctl_t;

  typedef struct packed {
    op_t  op;
    logic err;
    logic clr_last;
    logic corner_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/tgss_ram.sv =====
`default_nettype none

module tgss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/tgss_ctrl.sv =====
`default_nettype none

`include "trilinear_gather_scatter_store_core_macros.svh"

module tgss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tgss_pkg::sts_t sts,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  output tgss_pkg::ctl_t     ctl
);

  tgss_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgss_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tgss_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_next = tgss_pkg::ST_IDLE;
      end
      tgss_pkg::ST_IDLE: begin
        if (cmd_valid) state_next = tgss_pkg::ST_DECODE;
      end
      tgss_pkg::ST_DECODE: begin
        case (sts.op)
          tgss_pkg::OP_LOAD: state_next = tgss_pkg::ST_LOAD;
          tgss_pkg::OP_READ: state_next = tgss_pkg::ST_RD_ISSUE;
          default: state_next = sts.err ? tgss_pkg::ST_DONE : tgss_pkg::ST_W1;
        endcase
      end
      tgss_pkg::ST_LOAD:     state_next = tgss_pkg::ST_DONE;
      tgss_pkg::ST_RD_ISSUE: state_next = tgss_pkg::ST_RD_TAKE;
      tgss_pkg::ST_RD_TAKE:  state_next = tgss_pkg::ST_DONE;
      tgss_pkg::ST_W1:       state_next = tgss_pkg::ST_W2;
      tgss_pkg::ST_W2:       state_next = tgss_pkg::ST_W3;
      tgss_pkg::ST_W3:       state_next = tgss_pkg::ST_M1;
      tgss_pkg::ST_M1:       state_next = tgss_pkg::ST_M2;
      tgss_pkg::ST_M2:       state_next = tgss_pkg::ST_TERM;
      tgss_pkg::ST_TERM:     state_next = tgss_pkg::ST_ACC;
      tgss_pkg::ST_ACC: begin
        state_next = sts.corner_last ? tgss_pkg::ST_DONE : tgss_pkg::ST_W1;
      end
      tgss_pkg::ST_DONE: begin
        if (sts.out_free) state_next = tgss_pkg::ST_IDLE;
      end
      default: state_next = tgss_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl       = '0;
    cmd_stall = 1'b1;
    case (state)
      tgss_pkg::ST_CLEAR:    ctl.clr_step = 1'b1;
      tgss_pkg::ST_IDLE: begin
        cmd_stall   = 1'b0;
        ctl.capture = cmd_valid;
      end
      tgss_pkg::ST_DECODE:   ctl.decode   = 1'b1;
      tgss_pkg::ST_LOAD:     ctl.ld_write = 1'b1;
      tgss_pkg::ST_RD_ISSUE: ctl.rd_issue = 1'b1;
      tgss_pkg::ST_RD_TAKE:  ctl.rd_take  = 1'b1;
      tgss_pkg::ST_W1:       ctl.w1       = 1'b1;
      tgss_pkg::ST_W2:       ctl.w2       = 1'b1;
      tgss_pkg::ST_W3:       ctl.w3       = 1'b1;
      tgss_pkg::ST_M1:       ctl.m1       = 1'b1;
      tgss_pkg::ST_M2:       ctl.m2       = 1'b1;
      tgss_pkg::ST_TERM:     ctl.term     = 1'b1;
      tgss_pkg::ST_ACC:      ctl.acc      = 1'b1;
      tgss_pkg::ST_DONE:     ctl.finish   = sts.out_free;
      default: ctl = '0;
    endcase
  end

  `TGSS_ASSERT_ALWAYS(a_reset_clears, rst |=> state == tgss_pkg::ST_CLEAR, "reset did not start clear pass")
  `TGSS_ASSERT_RUN(a_last_corner, (state == tgss_pkg::ST_ACC && sts.corner_last) |=> state == tgss_pkg::ST_DONE, "eighth corner did not end the walk")
  `TGSS_ASSERT_RUN(a_done_frees, (state == tgss_pkg::ST_DONE && sts.out_free) |=> state == tgss_pkg::ST_IDLE, "finished item did not release the input")

endmodule

`default_nettype wire

// ===== sv/tgss_dpath.sv =====
`default_nettype none

module tgss_dpath #(
  parameter int EXTENT_X    = 4,
  parameter int EXTENT_Y    = 4,
  parameter int EXTENT_Z    = 4,
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tgss_pkg::ctl_t     ctl,
  output tgss_pkg::sts_t          sts,
  input  wire tgss_pkg::cmd_beat_t cmd_beat,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output tgss_pkg::rsp_beat_t     rsp_beat
);

  localparam int DEPTH = EXTENT_X * EXTENT_Y * EXTENT_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int EMAX  = (EXTENT_X > EXTENT_Y) ?
                         ((EXTENT_X > EXTENT_Z) ? EXTENT_X : EXTENT_Z) :
                         ((EXTENT_Y > EXTENT_Z) ? EXTENT_Y : EXTENT_Z);
  localparam int CW    = $clog2(EMAX);
  localparam int PW    = ((FRAC_BITS > tgss_pkg::POS_W) ? FRAC_BITS : tgss_pkg::POS_W) + 1;
  localparam int WW    = FRAC_BITS + 1;
  localparam int MW    = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam int RW    = MW + tgss_pkg::MUL_W + 1;
  localparam int TW    = MW + 2;
  localparam int NW    = MW + 3;
  localparam int SW    = MW + 4;
  localparam int OUTW  = (VALUE_WIDTH < tgss_pkg::OUT_W) ? VALUE_WIDTH : tgss_pkg::OUT_W;
  localparam int EXT_A [3] = '{EXTENT_X, EXTENT_Y, EXTENT_Z};

  localparam logic [PW-1:0] UNIT_P = PW'(1) << FRAC_BITS;
  localparam logic [WW-1:0] UNIT_W = WW'(1) << FRAC_BITS;
  localparam logic [tgss_pkg::PROD_W-1:0] HALF_P =
    tgss_pkg::PROD_W'(1) << (FRAC_BITS - 1);

  tgss_pkg::cmd_beat_t cmd_q;
  logic [AW-1:0]       base_q;
  logic [FRAC_BITS-1:0] frac_q [3];
  logic [2:0]          corner_q;
  logic [AW-1:0]       clr_addr;
  logic [tgss_pkg::PROD_W-1:0] prod, plo;
  logic [tgss_pkg::MUL_W-1:0]  wgt;
  logic                neg_q;
  logic [MW-1:0]       mag_q;
  logic signed [VALUE_WIDTH-1:0] ent_q;
  logic signed [TW-1:0] term_q;
  logic signed [SW-1:0] sum_q;
  logic [31:0]         res_q;

  // Axis split: remove the stagger, take the cell and the fraction.
  logic [tgss_pkg::POS_W-1:0] pos_a [3];
  logic                sh_a [3];
  logic [2:0]          err_a;
  logic [FRAC_BITS-1:0] frac_c [3];
  logic [CW-1:0]       cell_c [3];

  assign pos_a[0] = cmd_q.pos_x;
  assign pos_a[1] = cmd_q.pos_y;
  assign pos_a[2] = cmd_q.pos_z;
  assign sh_a[0]  = cmd_q.shift_x;
  assign sh_a[1]  = cmd_q.shift_y;
  assign sh_a[2]  = cmd_q.shift_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [PW-1:0] pe, p, whole;
    assign pe          = PW'(pos_a[a]);
    assign p           = pe - (sh_a[a] ? UNIT_P : '0);
    assign whole       = p >> FRAC_BITS;
    assign err_a[a]    = (sh_a[a] && (pe < UNIT_P)) || (whole >= PW'(EXT_A[a] - 1));
    assign frac_c[a]   = p[FRAC_BITS-1:0];
    assign cell_c[a]   = whole[CW-1:0];
  end

  logic [AW-1:0] base_c, idx;
  assign base_c = AW'(cell_c[0]) + AW'(cell_c[1] * EXTENT_X)
                + AW'(cell_c[2] * (EXTENT_X * EXTENT_Y));
  assign idx = base_q + AW'(corner_q[0])
             + (corner_q[1] ? AW'(EXTENT_X) : '0)
             + (corner_q[2] ? AW'(EXTENT_X * EXTENT_Y) : '0);

  logic [WW-1:0] wx, wy, wz;
  assign wx = corner_q[0] ? {1'b0, frac_q[0]} : UNIT_W - {1'b0, frac_q[0]};
  assign wy = corner_q[1] ? {1'b0, frac_q[1]} : UNIT_W - {1'b0, frac_q[1]};
  assign wz = corner_q[2] ? {1'b0, frac_q[2]} : UNIT_W - {1'b0, frac_q[2]};

  // Shared multiplier.
  logic [tgss_pkg::MUL_W-1:0]  mul_a, mul_b, rnd;
  logic [tgss_pkg::PROD_W-1:0] product;

  assign rnd = tgss_pkg::MUL_W'((prod + HALF_P) >> FRAC_BITS);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (ctl.w1) begin
      mul_a = tgss_pkg::MUL_W'(wx);
      mul_b = tgss_pkg::MUL_W'(wy);
    end else if (ctl.w2) begin
      mul_a = rnd;
      mul_b = tgss_pkg::MUL_W'(wz);
    end else if (ctl.m1) begin
      mul_a = tgss_pkg::MUL_W'(mag_q[tgss_pkg::CHUNK_W-1:0]);
      mul_b = wgt;
    end else if (ctl.m2) begin
      mul_a = tgss_pkg::MUL_W'(mag_q[MW-1:tgss_pkg::CHUNK_W]);
      mul_b = wgt;
    end
  end

  assign product = tgss_pkg::PROD_W'(mul_a) * tgss_pkg::PROD_W'(mul_b);

  // Store.
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr, addr_w;
  logic [VALUE_WIDTH-1:0] mem_wdata, rdata;
  logic                   addr_ok;

  assign addr_w  = AW'(cmd_q.entry_address);
  assign addr_ok = int'(cmd_q.entry_address) < DEPTH;

  // Value to be weighed, before its sign and magnitude are split.
  logic signed [MW-1:0] vsrc;
  assign vsrc = (cmd_q.command == tgss_pkg::OP_GATHER) ?
                MW'($signed(rdata)) : MW'(cmd_q.value);

  // Weighted term.
  logic [RW-1:0] r_full;
  logic [TW-1:0] term_mag;
  assign r_full = (RW'(prod) << (tgss_pkg::CHUNK_W - FRAC_BITS))
                + ((RW'(plo) + RW'(HALF_P)) >> FRAC_BITS);
  assign term_mag = TW'(r_full);

  // Saturations.
  logic signed [NW-1:0] snew;
  logic [VALUE_WIDTH-1:0] sc_sat, ld_sat;
  logic signed [MW-1:0] lv;
  logic [OUTW-1:0] rd_sat, gs_sat;

  assign snew   = NW'(ent_q) + NW'(term_q);
  assign sc_sat = (&snew[NW-1:VALUE_WIDTH-1] || ~|snew[NW-1:VALUE_WIDTH-1]) ?
                  snew[VALUE_WIDTH-1:0] :
                  {snew[NW-1], {(VALUE_WIDTH-1){~snew[NW-1]}}};
  assign lv     = MW'(cmd_q.value);
  assign ld_sat = (&lv[MW-1:VALUE_WIDTH-1] || ~|lv[MW-1:VALUE_WIDTH-1]) ?
                  lv[VALUE_WIDTH-1:0] :
                  {lv[MW-1], {(VALUE_WIDTH-1){~lv[MW-1]}}};
  assign rd_sat = (&rdata[VALUE_WIDTH-1:OUTW-1] || ~|rdata[VALUE_WIDTH-1:OUTW-1]) ?
                  rdata[OUTW-1:0] :
                  {rdata[VALUE_WIDTH-1], {(OUTW-1){~rdata[VALUE_WIDTH-1]}}};
  assign gs_sat = (&sum_q[SW-1:OUTW-1] || ~|sum_q[SW-1:OUTW-1]) ?
                  sum_q[OUTW-1:0] :
                  {sum_q[SW-1], {(OUTW-1){~sum_q[SW-1]}}};

  always_comb begin
    mem_we    = ctl.clr_step || (ctl.ld_write && addr_ok) ||
                (ctl.acc && (cmd_q.command == tgss_pkg::OP_SCATTER));
    mem_waddr = ctl.clr_step ? clr_addr : (ctl.ld_write ? addr_w : idx);
    mem_wdata = ctl.clr_step ? '0 : (ctl.ld_write ? ld_sat : sc_sat);
    mem_re    = ctl.rd_issue || ctl.w1;
    mem_raddr = ctl.rd_issue ? addr_w : idx;
  end

  tgss_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.clr_step) clr_addr <= clr_addr + AW'(1);
      if (ctl.finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q    <= cmd_beat;
      corner_q <= '0;
      sum_q    <= '0;
    end
    if (ctl.decode) begin
      base_q <= base_c;
      for (int a = 0; a < 3; a++) begin
        frac_q[a] <= frac_c[a];
      end
    end
    if (ctl.w1 || ctl.w2 || ctl.m1 || ctl.m2) prod <= product;
    if (ctl.w2) begin
      neg_q <= vsrc[MW-1];
      mag_q <= vsrc[MW-1] ? MW'(-vsrc) : MW'(vsrc);
      ent_q <= $signed(rdata);
    end
    if (ctl.w3) wgt <= rnd;
    if (ctl.m2) plo <= prod;
    if (ctl.term) term_q <= neg_q ? -term_mag : term_mag;
    if (ctl.acc) begin
      sum_q    <= sum_q + SW'(term_q);
      corner_q <= corner_q + 3'd1;
    end
    if (ctl.rd_take) res_q <= addr_ok ? 32'($signed(rd_sat)) : '0;
    if (ctl.finish) begin
      rsp_beat.status       <= err_a != 3'b000 &&
                               (cmd_q.command == tgss_pkg::OP_GATHER ||
                                cmd_q.command == tgss_pkg::OP_SCATTER);
      rsp_beat.result_value <= '0;
      if (cmd_q.command == tgss_pkg::OP_READ) begin
        rsp_beat.result_value <= res_q;
      end else if (cmd_q.command == tgss_pkg::OP_GATHER && err_a == 3'b000) begin
        rsp_beat.result_value <= 32'($signed(gs_sat));
      end
    end
  end

  assign sts.op          = cmd_q.command;
  assign sts.err         = |err_a;
  assign sts.clr_last    = clr_addr == AW'(DEPTH - 1);
  assign sts.corner_last = corner_q == 3'd7;
  assign sts.out_free    = !rsp_valid || !rsp_stall;

endmodule

`default_nettype wire

// ===== sv/trilinear_gather_scatter_store_core.sv =====
// Channel    Handshake              Beat
// command    cmd_valid / cmd_stall  cmd_beat: command, address, value, position, stagger
// response   rsp_valid / rsp_stall  rsp_beat: result_value, status
//
// Each command is decoded and ends by registering its response. Load writes the store; read
// issues then takes a store read; gather or scatter with a range error goes straight to the
// response, else it walks eight corners on the single shared multiplier, in W1, W2, W3, M1,
// M2, TERM and ACC per corner. The next beat is taken in the cycle after the response is set.
// After reset the store is swept to zero, one entry a cycle; no command is taken until it ends.
// A response held by rsp_stall stays in its register while the next beat is accepted.
`default_nettype none

module trilinear_gather_scatter_store_core #(
  parameter int EXTENT_X    = 4,
  parameter int EXTENT_Y    = 4,
  parameter int EXTENT_Z    = 4,
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_stall,
  input  wire tgss_pkg::cmd_beat_t cmd_beat,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output tgss_pkg::rsp_beat_t      rsp_beat
);

  // The controller sequences the clear sweep, the command decode, the load
  // and read steps and the corner walk; the datapath holds the store, the
  // multiplier and the response register.
  tgss_pkg::ctl_t ctl;
  tgss_pkg::sts_t sts;

  tgss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sts       (sts),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .ctl       (ctl)
  );

  tgss_dpath #(
    .EXTENT_X    (EXTENT_X),
    .EXTENT_Y    (EXTENT_Y),
    .EXTENT_Z    (EXTENT_Z),
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .cmd_beat  (cmd_beat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_beat  (rsp_beat)
  );

endmodule

`default_nettype wire

// ===== dv/tgss_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none

// Watches both channels, predicts every response from the accepted command
// beats and compares the two field by field.
module tgss_checker (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  input  wire logic                cmd_stall,
  input  wire tgss_pkg::cmd_beat_t cmd_beat,
  input  wire logic                rsp_valid,
  input  wire logic                rsp_stall,
  input  wire tgss_pkg::rsp_beat_t rsp_beat,
  output int                       mismatches,
  output int                       pending
);

  localparam int NX = 4, NY = 4, NZ = 4, FB = 16;
  localparam longint UNIT = 64'sd1 <<< FB;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  longint              grid [NX*NY*NZ];
  tgss_pkg::rsp_beat_t expected_rsp [$];

  function automatic longint clamp(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint rshift(longint x);
    return (x + (64'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  // Magnitude rounding, sign put back afterwards.
  function automatic longint scale(longint v, longint w);
    longint m;
    longint r;
    m = (v < 0) ? -v : v;
    r = (m * w + (64'sd1 <<< (FB - 1))) >>> FB;
    return (v < 0) ? -r : r;
  endfunction

  function automatic bit split_axis(logic [17:0] p, logic s, int ext,
                                    output int b, output longint f);
    longint q;
    q = longint'(p) - (s ? UNIT : 0);
    b = 0;
    f = 0;
    if (q < 0) return 0;
    if ((q >>> FB) >= ext - 1) return 0;
    b = int'(q >>> FB);
    f = q & (UNIT - 1);
    return 1;
  endfunction

  function automatic tgss_pkg::rsp_beat_t predict_rsp(tgss_pkg::cmd_beat_t c);
    tgss_pkg::rsp_beat_t r;
    int bx, by, bz, idx;
    longint fx, fy, fz, wx, wy, wz, w, sum;
    bit ok;
    r = '0;
    case (c.command)
      tgss_pkg::OP_LOAD: grid[c.entry_address] = longint'(c.value);
      tgss_pkg::OP_READ: r.result_value = 32'(grid[c.entry_address]);
      default: begin
        ok = split_axis(c.pos_x, c.shift_x, NX, bx, fx);
        ok = split_axis(c.pos_y, c.shift_y, NY, by, fy) && ok;
        ok = split_axis(c.pos_z, c.shift_z, NZ, bz, fz) && ok;
        if (!ok) begin
          r.status = 1'b1;
        end else begin
          sum = 0;
          for (int k = 0; k < 8; k++) begin
            wx = k[0] ? fx : UNIT - fx;
            wy = k[1] ? fy : UNIT - fy;
            wz = k[2] ? fz : UNIT - fz;
            w = rshift(rshift(wx * wy) * wz);
            idx = bx + k[0] + (by + k[1]) * NX + (bz + k[2]) * NX * NY;
            if (c.command == tgss_pkg::OP_GATHER) sum += scale(grid[idx], w);
            else grid[idx] = clamp(grid[idx] + scale(longint'(c.value), w));
          end
          if (c.command == tgss_pkg::OP_GATHER) r.result_value = 32'(clamp(sum));
        end
      end
    endcase
    return r;
  endfunction

  assign pending = expected_rsp.size();

  always @(posedge clk) begin
    tgss_pkg::rsp_beat_t want;
    if (rst) begin
      foreach (grid[i]) grid[i] = 0;
      expected_rsp.delete();
      mismatches <= 0;
    end else begin
      // The response is checked before this edge's command is predicted;
      // a response can never come from the same edge's command.
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          if (mismatches < 10) $display("unexpected response %h", rsp_beat);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_rsp.pop_front();
          if (want.result_value !== rsp_beat.result_value ||
              want.status !== rsp_beat.status) begin
            if (mismatches < 10)
              $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                       want.result_value, want.status,
                       rsp_beat.result_value, rsp_beat.status);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (cmd_valid && !cmd_stall) expected_rsp.push_back(predict_rsp(cmd_beat));
    end
  end
endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none

// Stimulus and verdict. Every beat is predicted and checked in tgss_checker.
module tb_top;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  tgss_pkg::cmd_beat_t cmd_beat = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  tgss_pkg::rsp_beat_t rsp_beat;
  int                  mismatches;
  int                  pending;

  // Idling percentages for the sender and the receiver.
  int  send_idle = 21;
  int  recv_idle = 51;
  // Set while the receiver is held off for a long stretch.
  bit  hold_rsp = 1'b0;
  int  quiet_cycles = 0;

  trilinear_gather_scatter_store_core uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_beat(cmd_beat),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_beat(rsp_beat)
  );

  tgss_checker chk (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_beat(cmd_beat),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_beat(rsp_beat),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: random stall, or a solid hold-off while hold_rsp is set.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle);
    end
  end

  // Watchdog: the reset sweep and the long hold-off both fit well inside.
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Positions near the cell edges are favoured so that the range checks are hit.
  function automatic logic [17:0] pick_pos();
    case ($urandom_range(5))
      0: return 18'($urandom_range(3) << 16);
      1: return 18'(($urandom_range(3) << 16) - 1);
      2: return 18'h3ffff;
      default: return 18'($urandom_range(18'h2ffff, 18'h0));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'($signed($urandom_range(20'hfffff)) - 32'sd524288);
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic tgss_pkg::cmd_beat_t random_beat();
    tgss_pkg::cmd_beat_t b;
    b.command       = tgss_pkg::op_t'($urandom_range(3));
    b.entry_address = 6'($urandom_range(63));
    b.value         = pick_value();
    b.pos_x         = pick_pos();
    b.pos_y         = pick_pos();
    b.pos_z         = pick_pos();
    b.shift_x       = ($urandom_range(3) == 0);
    b.shift_y       = ($urandom_range(3) == 0);
    b.shift_z       = ($urandom_range(3) == 0);
    return b;
  endfunction

  // Offers one beat, idling first at the sender's rate, and waits for acceptance.
  task automatic send_beat(tgss_pkg::cmd_beat_t b);
    while ($urandom_range(99) < send_idle) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_beat  <= b;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic directed_beat(tgss_pkg::op_t op, logic [5:0] a, logic signed [31:0] v,
                               logic [17:0] x, logic [17:0] y, logic [17:0] z,
                               logic [2:0] sh);
    tgss_pkg::cmd_beat_t b;
    b = '{op, a, v, x, y, z, sh[0], sh[1], sh[2]};
    send_beat(b);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extremes, every command, the range error and saturation.
    directed_beat(tgss_pkg::OP_READ, 6'd0, 32'sd0, 18'd0, 18'd0, 18'd0, 3'b000);
    directed_beat(tgss_pkg::OP_LOAD, 6'd0, 32'sh7fffffff, 18'd0, 18'd0, 18'd0, 3'b000);
    directed_beat(tgss_pkg::OP_LOAD, 6'd63, 32'sh80000000,
                  18'h3ffff, 18'h3ffff, 18'h3ffff, 3'b111);
    directed_beat(tgss_pkg::OP_LOAD, 6'd1, 32'sh7fffffff, 18'd0, 18'd0, 18'd0, 3'b000);
    directed_beat(tgss_pkg::OP_READ, 6'd63, 32'sd0, 18'd0, 18'd0, 18'd0, 3'b000);
    directed_beat(tgss_pkg::OP_READ, 6'd0, 32'sd0, 18'd0, 18'd0, 18'd0, 3'b000);
    directed_beat(tgss_pkg::OP_GATHER, 6'd0, 32'sd0, 18'h08000, 18'd0, 18'd0, 3'b000);
    directed_beat(tgss_pkg::OP_GATHER, 6'd0, 32'sd0, 18'd0, 18'd0, 18'd0, 3'b000);
    // Scatter overflow onto an entry already at its maximum.
    directed_beat(tgss_pkg::OP_SCATTER, 6'd0, 32'sh7fffffff, 18'd0, 18'd0, 18'd0, 3'b000);
    directed_beat(tgss_pkg::OP_SCATTER, 6'd0, 32'sh80000000,
                  18'h2ffff, 18'h2ffff, 18'h2ffff, 3'b000);
    directed_beat(tgss_pkg::OP_READ, 6'd63, 32'sd0, 18'd0, 18'd0, 18'd0, 3'b000);
    // Range errors: below zero after the stagger, and the last cell on the y and z axes.
    directed_beat(tgss_pkg::OP_GATHER, 6'd0, 32'sd0, 18'h0ffff, 18'd0, 18'd0, 3'b001);
    directed_beat(tgss_pkg::OP_SCATTER, 6'd0, 32'sd100, 18'd0, 18'h30000, 18'd0, 3'b000);
    directed_beat(tgss_pkg::OP_GATHER, 6'd0, 32'sd0, 18'd0, 18'd0, 18'h3ffff, 3'b000);
    directed_beat(tgss_pkg::OP_GATHER, 6'd0, 32'sd0,
                  18'h3ffff, 18'h3ffff, 18'h3ffff, 3'b111);
    directed_beat(tgss_pkg::OP_SCATTER, 6'd0, 32'sh12345678,
                  18'h1ffff, 18'h1ffff, 18'h1ffff, 3'b111);
    directed_beat(tgss_pkg::OP_GATHER, 6'd0, 32'sd0,
                  18'h18000, 18'h14000, 18'h1c000, 3'b000);
    drain();

    // Long hold-off on the response side while commands keep coming.
    hold_rsp = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_rsp = 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++) send_beat(random_beat());
      end
    join
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 21 : (phase == 1) ? 51 : 0;
      recv_idle = (phase == 0) ? 51 : (phase == 1) ? 21 : 0;
      for (int i = 0; i < 370; i++) begin
        send_beat(random_beat());
        // Once per phase the sender waits for every outstanding response.
        if (i == 150) drain();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
